FILE: src/nnis_pkg.sv
// Shared constants, codes and types for the nearest-neighbour image scaler.
// Depends on nothing; the interfaces, the top level and nnis_geom import it.
package nnis_pkg;

    // Default frame-store geometry
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Field widths
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int IN_DIM_W   = 9;
    localparam int P_W        = 10;
    localparam int STATUS_W   = 2;

    // Geometry arithmetic widths, sized for frame dimensions up to 4096
    localparam int DIM_W     = 13;
    localparam int PROD_W    = DIM_W + P_W;
    localparam int OUT_DIM_W = PROD_W - 6;
    localparam int Q_W       = 7;

    localparam int PCT_BASE = 100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd2;

    // Register reset values
    localparam logic [IN_DIM_W-1:0] IN_WIDTH_RST  = 9'd256;
    localparam logic [IN_DIM_W-1:0] IN_HEIGHT_RST = 9'd256;
    localparam logic [P_W-1:0]      SCALE_RST     = 10'd100;

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd2;

    // Output geometry handed from the setup unit to the datapath
    typedef struct packed {
        logic                 busy;
        logic [OUT_DIM_W-1:0] out_h;
        logic [OUT_DIM_W-1:0] out_w;
        logic [Q_W-1:0]       step_q;
        logic [P_W-1:0]       step_r;
    } geom_t;

endpackage

FILE: src/nnis_req_if.sv
// Request channel of the scaler: opcode and source pixel.
// Depends on nnis_pkg.
interface nnis_req_if
    import nnis_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            opcode;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

FILE: src/nnis_rsp_if.sv
// Response channel of the scaler: emitted pixel, frame end mark and status.
// Depends on nnis_pkg.
interface nnis_rsp_if
    import nnis_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     red_out;
    logic [CH_W-1:0]     green_out;
    logic [CH_W-1:0]     blue_out;
    logic                last_pixel;
    logic [STATUS_W-1:0] status;

    modport source (output valid, red_out, green_out, blue_out, last_pixel, status,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, last_pixel, status,
                    output ready);
endinterface

FILE: src/nearest_neighbor_image_scaler.sv
// Nearest-neighbour RGB image scaler: top level with frame store and walkers.
// Depends on nnis_pkg, nnis_req_if, nnis_rsp_if, nnis_ram and nnis_geom.
//
// Load a source frame of in_width x in_height pixels in row-major order with
// opcode 0 transactions (one per ready cycle, no response), then issue opcode 1
// transactions to fetch the resized frame, also row-major, one response each;
// last_pixel marks the end of the scaled frame, after which fetching wraps to
// the first pixel. Output size is floor(dim * scale_percent / 100) and each
// output pixel copies the source pixel at floor(pos * 100 / scale_percent). A
// fetch passes through the synchronous frame-store read and then lands the
// pixel in the output register. Source positions are advanced
// incrementally with a precomputed quotient and remainder of 100 / scale, so
// no divider sits on the fetch path. After reset and after every configuration
// write the geometry unit recomputes the output size by reciprocal
// multiplication and the step on a bit-serial divider; req.ready stays low
// until the unit is idle again, and the divider is skipped for a zero scale.
// Reloading after a complete frame starts a new frame. Fetches before the frame
// is complete return status 2; a zero scale or an empty output returns status 1
// without moving the output position. The frame store is not cleared at reset.
module nearest_neighbor_image_scaler
    import nnis_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    nnis_req_if.sink              req,
    nnis_rsp_if.source            rsp
);
    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW1    = ADDR_W + 1;

    // Configuration registers
    logic [IN_DIM_W-1:0] in_width_reg;
    logic [IN_DIM_W-1:0] in_height_reg;
    logic [P_W-1:0]      scale_reg;
    logic                start_reg;

    // Load walker
    logic [RW-1:0] ld_row_reg, ld_row_next;
    logic [CW-1:0] ld_col_reg, ld_col_next;
    logic          loaded_reg, loaded_next;

    // Fetch walker: output position plus source position and remainders
    logic [OUT_DIM_W-1:0] o_row_reg, o_row_next;
    logic [OUT_DIM_W-1:0] o_col_reg, o_col_next;
    logic [RW-1:0]        sr_reg, sr_next;
    logic [P_W-1:0]       srem_reg, srem_next;
    logic [CW-1:0]        sc_reg, sc_next;
    logic [P_W-1:0]       crem_reg, crem_next;

    // Read stage and output register
    logic                pend_reg;
    logic [STATUS_W-1:0] pend_status_reg;
    logic                pend_last_reg;
    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_pix_reg;
    logic                out_last_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [DIM_W-1:0]    dim_w;
    logic [DIM_W-1:0]    dim_h;
    geom_t               geom;
    logic                req_acc;
    logic                ld_acc;
    logic                fe_acc;
    logic                fetch_ok;
    logic [STATUS_W-1:0] fe_status;
    logic                fe_last;
    logic                col_end;
    logic [CW-1:0]       w_m1;
    logic [RW-1:0]       h_m1;
    logic [RW-1:0]       ld_base_row;
    logic [CW-1:0]       ld_base_col;
    logic [P_W:0]        crem_sum;
    logic [P_W:0]        srem_sum;
    logic [AW1-1:0]      wr_addr_full;
    logic [AW1-1:0]      rd_addr_full;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [PIX_W-1:0]    ram_rdata;

    // Clamp the geometry: zero acts as one, anything above the store size as the maximum
    always_comb
    begin
        if (in_width_reg == '0)
        begin
            dim_w = DIM_W'(1);
        end
        else if (DIM_W'(in_width_reg) > DIM_W'(MAX_WIDTH))
        begin
            dim_w = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            dim_w = DIM_W'(in_width_reg);
        end
        if (in_height_reg == '0)
        begin
            dim_h = DIM_W'(1);
        end
        else if (DIM_W'(in_height_reg) > DIM_W'(MAX_HEIGHT))
        begin
            dim_h = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            dim_h = DIM_W'(in_height_reg);
        end
    end

    assign w_m1 = CW'(dim_w - DIM_W'(1));
    assign h_m1 = RW'(dim_h - DIM_W'(1));

    nnis_geom u_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .dim_w (dim_w),
        .dim_h (dim_h),
        .scale (scale_reg),
        .geom  (geom)
    );

    // Hold requests while geometry is being worked out, a read is in flight,
    // or a response is stuck in the output register
    assign req.ready = !geom.busy && !pend_reg && (!out_valid_reg || rsp.ready);
    assign req_acc   = req.valid && req.ready;
    assign ld_acc    = req_acc && (req.opcode == OP_LOAD);
    assign fe_acc    = req_acc && (req.opcode == OP_FETCH);

    // Fetch classification
    always_comb
    begin
        fetch_ok = loaded_reg && (scale_reg != '0) && (geom.out_h != '0) && (geom.out_w != '0);
        if (!loaded_reg)
        begin
            fe_status = STATUS_NOT_LOADED;
        end
        else if (!fetch_ok)
        begin
            fe_status = STATUS_EMPTY;
        end
        else
        begin
            fe_status = STATUS_OK;
        end
        col_end = (o_col_reg == geom.out_w - 1'b1);
        fe_last = fetch_ok && col_end && (o_row_reg == geom.out_h - 1'b1);
    end

    // A load after a complete frame restarts the frame at the origin
    assign ld_base_row = loaded_reg ? '0 : ld_row_reg;
    assign ld_base_col = loaded_reg ? '0 : ld_col_reg;

    assign crem_sum = {1'b0, crem_reg} + (P_W + 1)'(geom.step_r);
    assign srem_sum = {1'b0, srem_reg} + (P_W + 1)'(geom.step_r);

    // Next state of both walkers
    always_comb
    begin
        ld_row_next = ld_row_reg;
        ld_col_next = ld_col_reg;
        loaded_next = loaded_reg;
        o_row_next  = o_row_reg;
        o_col_next  = o_col_reg;
        sr_next     = sr_reg;
        srem_next   = srem_reg;
        sc_next     = sc_reg;
        crem_next   = crem_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_WIDTH, REG_IN_HEIGHT:
                begin
                    ld_row_next = '0;
                    ld_col_next = '0;
                    loaded_next = 1'b0;
                    o_row_next  = '0;
                    o_col_next  = '0;
                    sr_next     = '0;
                    srem_next   = '0;
                    sc_next     = '0;
                    crem_next   = '0;
                end
                REG_SCALE:
                begin
                    o_row_next = '0;
                    o_col_next = '0;
                    sr_next    = '0;
                    srem_next  = '0;
                    sc_next    = '0;
                    crem_next  = '0;
                end
                default:
                begin
                    loaded_next = loaded_reg;
                end
            endcase
        end
        else if (ld_acc)
        begin
            if (loaded_reg)
            begin
                loaded_next = 1'b0;
                o_row_next  = '0;
                o_col_next  = '0;
                sr_next     = '0;
                srem_next   = '0;
                sc_next     = '0;
                crem_next   = '0;
            end
            if (ld_base_col == w_m1)
            begin
                ld_col_next = '0;
                if (ld_base_row == h_m1)
                begin
                    ld_row_next = '0;
                    loaded_next = 1'b1;
                end
                else
                begin
                    ld_row_next = ld_base_row + 1'b1;
                end
            end
            else
            begin
                ld_col_next = ld_base_col + 1'b1;
                ld_row_next = ld_base_row;
            end
        end
        else if (fe_acc && fetch_ok)
        begin
            if (fe_last)
            begin
                o_row_next = '0;
                o_col_next = '0;
                sr_next    = '0;
                srem_next  = '0;
                sc_next    = '0;
                crem_next  = '0;
            end
            else if (col_end)
            begin
                // Wrap to the next output row; step the source row by 100/scale
                o_col_next = '0;
                sc_next    = '0;
                crem_next  = '0;
                o_row_next = o_row_reg + 1'b1;
                if (srem_sum >= (P_W + 1)'(scale_reg))
                begin
                    srem_next = P_W'(srem_sum - (P_W + 1)'(scale_reg));
                    sr_next   = RW'((RW + Q_W + 1)'(sr_reg) + (RW + Q_W + 1)'(geom.step_q)
                                    + (RW + Q_W + 1)'(1));
                end
                else
                begin
                    srem_next = P_W'(srem_sum);
                    sr_next   = RW'((RW + Q_W + 1)'(sr_reg) + (RW + Q_W + 1)'(geom.step_q));
                end
            end
            else
            begin
                o_col_next = o_col_reg + 1'b1;
                if (crem_sum >= (P_W + 1)'(scale_reg))
                begin
                    crem_next = P_W'(crem_sum - (P_W + 1)'(scale_reg));
                    sc_next   = CW'((CW + Q_W + 1)'(sc_reg) + (CW + Q_W + 1)'(geom.step_q)
                                    + (CW + Q_W + 1)'(1));
                end
                else
                begin
                    crem_next = P_W'(crem_sum);
                    sc_next   = CW'((CW + Q_W + 1)'(sc_reg) + (CW + Q_W + 1)'(geom.step_q));
                end
            end
        end
    end

    // Frame store addressing: row * MAX_WIDTH + column
    assign wr_addr_full = AW1'(ld_base_row) * AW1'(MAX_WIDTH) + AW1'(ld_base_col);
    assign rd_addr_full = AW1'(sr_reg) * AW1'(MAX_WIDTH) + AW1'(sc_reg);
    assign ram_we       = ld_acc && !cfg_we;
    assign ram_addr     = ram_we ? wr_addr_full[ADDR_W-1:0] : rd_addr_full[ADDR_W-1:0];

    nnis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({req.red_in, req.green_in, req.blue_in}),
        .rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg  <= IN_WIDTH_RST;
            in_height_reg <= IN_HEIGHT_RST;
            scale_reg     <= SCALE_RST;
            start_reg     <= 1'b1;
            ld_row_reg    <= '0;
            ld_col_reg    <= '0;
            loaded_reg    <= 1'b0;
            o_row_reg     <= '0;
            o_col_reg     <= '0;
            sr_reg        <= '0;
            srem_reg      <= '0;
            sc_reg        <= '0;
            crem_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IN_WIDTH:
                    begin
                        in_width_reg <= cfg_data[IN_DIM_W-1:0];
                        start_reg    <= 1'b1;
                    end
                    REG_IN_HEIGHT:
                    begin
                        in_height_reg <= cfg_data[IN_DIM_W-1:0];
                        start_reg     <= 1'b1;
                    end
                    REG_SCALE:
                    begin
                        scale_reg <= cfg_data[P_W-1:0];
                        start_reg <= 1'b1;
                    end
                    default:
                    begin
                        start_reg <= 1'b0;
                    end
                endcase
            end
            ld_row_reg <= ld_row_next;
            ld_col_reg <= ld_col_next;
            loaded_reg <= loaded_next;
            o_row_reg  <= o_row_next;
            o_col_reg  <= o_col_next;
            sr_reg     <= sr_next;
            srem_reg   <= srem_next;
            sc_reg     <= sc_next;
            crem_reg   <= crem_next;

            // Advance a fetch into the read stage, then into the output register
            pend_reg <= fe_acc && !cfg_we;
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (fe_acc)
        begin
            pend_status_reg <= fe_status;
            pend_last_reg   <= fe_last;
        end
        if (pend_reg)
        begin
            out_status_reg <= pend_status_reg;
            out_last_reg   <= pend_last_reg;
            // Drop the memory data on error responses
            out_pix_reg    <= (pend_status_reg == STATUS_OK) ? ram_rdata : '0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.red_out    = out_pix_reg[PIX_W-1 -: CH_W];
    assign rsp.green_out  = out_pix_reg[CH_W +: CH_W];
    assign rsp.blue_out   = out_pix_reg[CH_W-1:0];
    assign rsp.last_pixel = out_last_reg;
    assign rsp.status     = out_status_reg;
endmodule

FILE: src/nnis_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module nnis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: src/nnis_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module nnis_div #(
    parameter int N = 23
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [N-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient,
    output logic [N-1:0] remainder
);
    localparam int CNT_W = (N > 1) ? $clog2(N) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N-1:0]     rem_reg;
    logic [N-1:0]     quo_reg;
    logic [N-1:0]     dvs_reg;
    logic [N:0]       shifted;
    logic [N:0]       diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[N-1]};
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: restore on a negative trial subtraction
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[N] ? shifted[N-1:0] : diff[N-1:0];
            if (N > 1)
            begin
                quo_reg <= {quo_reg[N-2:0], ~diff[N]};
            end
            else
            begin
                quo_reg <= N'(~diff[N]);
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

FILE: src/nnis_geom.sv
// Output geometry unit: output height and width by reciprocal multiplication, then the
// per-step source increment (quotient and remainder of 100 / scale) on a small divider.
// Depends on nnis_pkg and nnis_div.
module nnis_geom
    import nnis_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIM_W-1:0] dim_w,
    input  logic [DIM_W-1:0] dim_h,
    input  logic [P_W-1:0]   scale,
    output geom_t            geom
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_OH   = 2'd1;
    localparam logic [1:0] S_OW   = 2'd2;
    localparam logic [1:0] S_REC  = 2'd3;

    // floor(x / 100) as (x * RCP_100) >> RCP_SHIFT, exact for any x of PROD_W bits
    localparam int               RCP_W     = 24;
    localparam int               RCP_SHIFT = 30;
    localparam int               MUL_W     = PROD_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_100   = 24'd10737419;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [OUT_DIM_W-1:0] oh_reg;
    logic [OUT_DIM_W-1:0] ow_reg;
    logic [Q_W-1:0]       q_reg;
    logic [P_W-1:0]       r_reg;
    logic [MUL_W-1:0]     rcp_prod;
    logic [OUT_DIM_W-1:0] rcp_quo;
    logic                 div_start;
    logic [P_W-1:0]       div_dividend;
    logic                 div_done;
    logic [P_W-1:0]       div_quo;
    logic [P_W-1:0]       div_rem;
    logic                 scale_zero;

    assign scale_zero   = (scale == '0);
    assign div_dividend = P_W'(PCT_BASE);
    assign rcp_prod     = MUL_W'(prod_reg) * MUL_W'(RCP_100);
    assign rcp_quo      = rcp_prod[RCP_SHIFT +: OUT_DIM_W];

    // Sequence: output height, output width, then 100 / scale unless the scale is zero
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        if (start)
        begin
            state_next = S_OH;
        end
        else
        begin
            case (state_reg)
                S_OH:
                begin
                    state_next = S_OW;
                end
                S_OW:
                begin
                    if (!scale_zero)
                    begin
                        div_start  = 1'b1;
                        state_next = S_REC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                S_REC:
                begin
                    if (div_done)
                    begin
                        state_next = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(dim_h) * PROD_W'(scale);
        end
        else
        begin
            case (state_reg)
                S_OH:
                begin
                    oh_reg   <= rcp_quo;
                    prod_reg <= PROD_W'(dim_w) * PROD_W'(scale);
                end
                S_OW:
                begin
                    ow_reg <= rcp_quo;
                    if (scale_zero)
                    begin
                        q_reg <= '0;
                        r_reg <= '0;
                    end
                end
                S_REC:
                begin
                    if (div_done)
                    begin
                        q_reg <= div_quo[Q_W-1:0];
                        r_reg <= div_rem;
                    end
                end
                default:
                begin
                    q_reg <= q_reg;
                end
            endcase
        end
    end

    nnis_div #(
        .N (P_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (scale),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign geom.busy   = start || (state_reg != S_IDLE);
    assign geom.out_h  = oh_reg;
    assign geom.out_w  = ow_reg;
    assign geom.step_q = q_reg;
    assign geom.step_r = r_reg;
endmodule
